// ----- design/trilinear_volume_sampler_macros.svh -----
// Assertion macros for the trilinear volume sampler.
// Used by the top level only; the macros expect i_clk and i_rst_n in scope.
`ifndef TRILINEAR_VOLUME_SAMPLER_MACROS_SVH
`define TRILINEAR_VOLUME_SAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVS_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trilinear_volume_sampler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TVS_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trilinear_volume_sampler: next-cycle check failed");

`endif

// ----- design/tvs_pkg.sv -----
// Shared constants and types of the trilinear volume sampler.
// No dependencies; used by every module of the block except the generic tvs_ram.
package tvs_pkg;

    localparam int DIM_LIMIT   = 32;
    localparam int STORE_DEPTH = 32768;
    localparam int VOXEL_BITS  = 16;
    localparam int FRAC_BITS   = 8;

    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W  = 16;
    localparam int IN_VAL_W = 16;
    localparam int OUT_W    = 16;
    localparam int SIZE_W   = $clog2(DIM_LIMIT + 1);
    localparam int IDX_W    = $clog2(DIM_LIMIT);
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int ROW_W    = $clog2((DIM_LIMIT - 1) * DIM_LIMIT + 1);
    localparam int PLANE_W  = $clog2(DIM_LIMIT * DIM_LIMIT + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // One job handed from the front end to the back end.
    typedef struct packed {
        logic                  is_sample;
        logic [ADDR_W-1:0]     wr_index;
        logic [VOXEL_BITS-1:0] wr_value;
        logic [IDX_W-1:0]      x0;
        logic [IDX_W-1:0]      x1;
        logic [ROW_W-1:0]      row0;
        logic [ROW_W-1:0]      row1;
        logic [ADDR_W-1:0]     plane0;
        logic [ADDR_W-1:0]     plane1;
        logic [FRAC_BITS-1:0]  fx;
        logic [FRAC_BITS-1:0]  fy;
        logic [FRAC_BITS-1:0]  fz;
    } t_job;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [VOXEL_BITS-1:0] wdata;
    } t_ram_req;

    typedef struct packed {
        logic sampling;
        logic res_load;
    } t_back_stat;

endpackage

// ----- design/trilinear_volume_sampler.sv -----
// Trilinear volume sampler, top level. A voxel write is carried out as the back end pops it.
// A sample is started, makes eight voxel reads through the single RAM port, drains the
// last read and runs three blends; the front end registers each item before the queue.
// The back end takes no new job until the current sample has been handed to the output.
// Synchronous active-low reset clears control and sets each size register to 32;
// the voxel RAM is not cleared and holds unknown data until written.
module trilinear_volume_sampler (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   i_command,
    input  logic [tvs_pkg::ADDR_W-1:0]             i_voxel_index,
    input  logic signed [tvs_pkg::IN_VAL_W-1:0]    i_voxel_value,
    input  logic signed [tvs_pkg::COORD_W-1:0]     i_coord_x,
    input  logic signed [tvs_pkg::COORD_W-1:0]     i_coord_y,
    input  logic signed [tvs_pkg::COORD_W-1:0]     i_coord_z,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [tvs_pkg::OUT_W-1:0]       o_sample_value,
    input  logic                                   i_cfg_we,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [tvs_pkg::CFG_W-1:0]              i_cfg_data
);

    `include "trilinear_volume_sampler_macros.svh"

    logic [tvs_pkg::CFG_W-1:0]      r_size_x;
    logic [tvs_pkg::CFG_W-1:0]      r_size_y;
    logic [tvs_pkg::CFG_W-1:0]      r_size_z;

    logic                           q_push;
    logic                           q_ready;
    logic                           q_valid;
    logic                           q_pop;
    tvs_pkg::t_job                  front_job;
    tvs_pkg::t_job                  head_job;
    tvs_pkg::t_ram_req              ram_req;
    logic [tvs_pkg::VOXEL_BITS-1:0] ram_rdata;
    logic                           out_valid;
    tvs_pkg::t_back_stat            back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= tvs_pkg::CFG_W'(tvs_pkg::DIM_LIMIT);
            r_size_y <= tvs_pkg::CFG_W'(tvs_pkg::DIM_LIMIT);
            r_size_z <= tvs_pkg::CFG_W'(tvs_pkg::DIM_LIMIT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tvs_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                tvs_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                tvs_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tvs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_voxel_index (i_voxel_index),
        .i_voxel_value (i_voxel_value),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_size_x      (r_size_x),
        .i_size_y      (r_size_y),
        .i_size_z      (r_size_z),
        .o_q_push      (q_push),
        .o_job         (front_job),
        .i_q_ready     (q_ready)
    );

    tvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (head_job),
        .i_pop   (q_pop)
    );

    tvs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (head_job),
        .o_q_pop        (q_pop),
        .o_ram_req      (ram_req),
        .i_rdata        (ram_rdata),
        .o_out_valid    (out_valid),
        .o_sample_value (o_sample_value),
        .i_out_pop      (pop),
        .o_stat         (back_stat)
    );

    tvs_ram #(
        .WIDTH (tvs_pkg::VOXEL_BITS),
        .DEPTH (tvs_pkg::STORE_DEPTH)
    ) u_voxel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

    assign empty = !out_valid;

    // The front end raises full only while it holds a job that the queue cannot take.
    `TVS_CHECK(a_full_only_when_blocked, full, q_push && !q_ready)
    // A voxel write must never land in the middle of a sample's reads.
    `TVS_CHECK(a_no_write_while_sampling, ram_req.we, !back_stat.sampling)
    // A new result never overwrites one that has not been transferred.
    `TVS_CHECK(a_result_slot_free, back_stat.res_load, empty || pop)
    `TVS_CHECK_NEXT(a_result_visible, back_stat.res_load, !empty)

endmodule

// ----- design/tvs_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module tvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tvs_front.sv -----
// Front end: takes input items, clamps sample coordinates and forms the
// row and plane base addresses. Depends on tvs_pkg.
module tvs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_command,
    input  logic [tvs_pkg::ADDR_W-1:0]    i_voxel_index,
    input  logic signed [tvs_pkg::IN_VAL_W-1:0] i_voxel_value,
    input  logic signed [tvs_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [tvs_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [tvs_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [tvs_pkg::CFG_W-1:0]     i_size_x,
    input  logic [tvs_pkg::CFG_W-1:0]     i_size_y,
    input  logic [tvs_pkg::CFG_W-1:0]     i_size_z,
    output logic                          o_q_push,
    output tvs_pkg::t_job                 o_job,
    input  logic                          i_q_ready
);

    localparam int CL_W = tvs_pkg::IDX_W + tvs_pkg::FRAC_BITS;

    typedef struct packed {
        logic [tvs_pkg::IDX_W-1:0]     i0;
        logic [tvs_pkg::IDX_W-1:0]     i1;
        logic [tvs_pkg::FRAC_BITS-1:0] f;
    } t_axis;

    typedef struct packed {
        logic                               is_sample;
        logic [tvs_pkg::ADDR_W-1:0]         wr_index;
        logic [tvs_pkg::VOXEL_BITS-1:0]     wr_value;
        t_axis                              ax;
        t_axis                              ay;
        t_axis                              az;
        logic [tvs_pkg::SIZE_W-1:0]         sx;
        logic [tvs_pkg::PLANE_W-1:0]        plane_stride;
    } t_pre;

    function automatic logic [tvs_pkg::SIZE_W-1:0] eff_size(
        input logic [tvs_pkg::CFG_W-1:0] reg_val
    );
        logic [tvs_pkg::SIZE_W-1:0] res;
        if (reg_val == '0) begin
            res = tvs_pkg::SIZE_W'(1);
        end else if (reg_val > tvs_pkg::CFG_W'(tvs_pkg::DIM_LIMIT)) begin
            res = tvs_pkg::SIZE_W'(tvs_pkg::DIM_LIMIT);
        end else begin
            res = tvs_pkg::SIZE_W'(reg_val);
        end
        return res;
    endfunction

    // Clamp to 0 .. (size-1) in fixed point, then split into index and fraction.
    function automatic t_axis clamp_axis(
        input logic signed [tvs_pkg::COORD_W-1:0] coord,
        input logic [tvs_pkg::SIZE_W-1:0]         size
    );
        t_axis                        res;
        logic [tvs_pkg::IDX_W-1:0]    last;
        logic [CL_W-1:0]              hi;
        logic [CL_W-1:0]              cl;
        logic [tvs_pkg::SIZE_W-1:0]   next;
        last = tvs_pkg::IDX_W'(size - tvs_pkg::SIZE_W'(1));
        hi   = {last, {tvs_pkg::FRAC_BITS{1'b0}}};
        if (coord[tvs_pkg::COORD_W-1]) begin
            cl = '0;
        end else if (coord[tvs_pkg::COORD_W-2:0] > (tvs_pkg::COORD_W-1)'(hi)) begin
            cl = hi;
        end else begin
            cl = coord[CL_W-1:0];
        end
        res.i0 = cl[CL_W-1:tvs_pkg::FRAC_BITS];
        res.f  = cl[tvs_pkg::FRAC_BITS-1:0];
        next   = tvs_pkg::SIZE_W'(res.i0) + tvs_pkg::SIZE_W'(1);
        res.i1 = (next < size) ? tvs_pkg::IDX_W'(next) : res.i0;
        return res;
    endfunction

    logic                       r_a_valid;
    t_pre                       r_a;
    logic                       accept;
    logic [tvs_pkg::SIZE_W-1:0] sx;
    logic [tvs_pkg::SIZE_W-1:0] sy;
    logic [tvs_pkg::SIZE_W-1:0] sz;
    logic [2*tvs_pkg::SIZE_W-1:0]                 stride_full;
    logic [tvs_pkg::IDX_W+tvs_pkg::SIZE_W-1:0]    row0_full;
    logic [tvs_pkg::IDX_W+tvs_pkg::SIZE_W-1:0]    row1_full;
    logic [tvs_pkg::IDX_W+tvs_pkg::PLANE_W-1:0]   plane0_full;
    logic [tvs_pkg::IDX_W+tvs_pkg::PLANE_W-1:0]   plane1_full;

    assign sx = eff_size(i_size_x);
    assign sy = eff_size(i_size_y);
    assign sz = eff_size(i_size_z);
    assign stride_full = sx * sy;

    assign o_full = r_a_valid && !i_q_ready;
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_a_valid <= 1'b0;
        end
        if (accept) begin
            r_a.is_sample    <= (i_command == tvs_pkg::CMD_SAMPLE);
            r_a.wr_index     <= i_voxel_index;
            r_a.wr_value     <= tvs_pkg::VOXEL_BITS'(i_voxel_value);
            r_a.ax           <= clamp_axis(i_coord_x, sx);
            r_a.ay           <= clamp_axis(i_coord_y, sy);
            r_a.az           <= clamp_axis(i_coord_z, sz);
            r_a.sx           <= sx;
            r_a.plane_stride <= stride_full[tvs_pkg::PLANE_W-1:0];
        end
    end

    // Base addresses of the two rows and two planes around the sample.
    assign row0_full   = r_a.ay.i0 * r_a.sx;
    assign row1_full   = r_a.ay.i1 * r_a.sx;
    assign plane0_full = r_a.az.i0 * r_a.plane_stride;
    assign plane1_full = r_a.az.i1 * r_a.plane_stride;

    assign o_q_push = r_a_valid;

    always_comb begin
        o_job.is_sample = r_a.is_sample;
        o_job.wr_index  = r_a.wr_index;
        o_job.wr_value  = r_a.wr_value;
        o_job.x0        = r_a.ax.i0;
        o_job.x1        = r_a.ax.i1;
        o_job.row0      = row0_full[tvs_pkg::ROW_W-1:0];
        o_job.row1      = row1_full[tvs_pkg::ROW_W-1:0];
        o_job.plane0    = plane0_full[tvs_pkg::ADDR_W-1:0];
        o_job.plane1    = plane1_full[tvs_pkg::ADDR_W-1:0];
        o_job.fx        = r_a.ax.f;
        o_job.fy        = r_a.ay.f;
        o_job.fz        = r_a.az.f;
    end

endmodule

// ----- design/tvs_queue.sv -----
// Short job queue between the front end and the back end.
// Depends on tvs_pkg.
module tvs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tvs_pkg::t_job i_data,
    output logic          o_ready,
    output logic          o_valid,
    output tvs_pkg::t_job o_data,
    input  logic          i_pop
);

    tvs_pkg::t_job              r_slot [tvs_pkg::QUEUE_DEPTH];
    logic [tvs_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [tvs_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [tvs_pkg::QCNT_W-1:0] r_count;
    logic                       do_push;
    logic                       do_pop;

    function automatic logic [tvs_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tvs_pkg::QPTR_W-1:0] p
    );
        logic [tvs_pkg::QPTR_W-1:0] res;
        if (p == tvs_pkg::QPTR_W'(tvs_pkg::QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + tvs_pkg::QPTR_W'(1);
        end
        return res;
    endfunction

    assign o_ready = (r_count != tvs_pkg::QCNT_W'(tvs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + tvs_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - tvs_pkg::QCNT_W'(1);
            end
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- design/tvs_back.sv -----
// Back end: carries out voxel writes, reads the eight neighbors of a sample
// and blends them with one shared blender. Depends on tvs_pkg.
module tvs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  tvs_pkg::t_job                      i_q_data,
    output logic                               o_q_pop,
    output tvs_pkg::t_ram_req                  o_ram_req,
    input  logic [tvs_pkg::VOXEL_BITS-1:0]     i_rdata,
    output logic                               o_out_valid,
    output logic signed [tvs_pkg::OUT_W-1:0]   o_sample_value,
    input  logic                               i_out_pop,
    output tvs_pkg::t_back_stat                o_stat
);

    localparam int VB = tvs_pkg::VOXEL_BITS;
    localparam int FB = tvs_pkg::FRAC_BITS;
    localparam int PROD_W = VB + 1 + FB + 1;
    localparam int SUM_W  = PROD_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_Y0,
        ST_Y1,
        ST_Z
    } t_state;

    // a*(2^F - f) + b*f rewritten as a*2^F + (b - a)*f, then a floor shift.
    function automatic logic signed [VB-1:0] blend(
        input logic signed [VB-1:0] a,
        input logic signed [VB-1:0] b,
        input logic [FB-1:0]        f
    );
        logic signed [VB:0]      diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [SUM_W-1:0]  sum;
        diff = (VB+1)'(b) - (VB+1)'(a);
        prod = diff * $signed({1'b0, f});
        sum  = (SUM_W'(a) <<< FB) + SUM_W'(prod);
        return sum[FB+VB-1:FB];
    endfunction

    t_state                    r_state,    n_state;
    tvs_pkg::t_job             r_job,      n_job;
    logic [2:0]                r_k,        n_k;
    logic                      r_rvalid,   n_rvalid;
    logic [2:0]                r_rk,       n_rk;
    logic signed [VB-1:0]      r_lo,       n_lo;
    logic signed [VB-1:0]      r_c [4];
    logic signed [VB-1:0]      n_c [4];
    logic signed [VB-1:0]      r_c0,       n_c0;
    logic signed [VB-1:0]      r_c1,       n_c1;
    logic                      r_out_valid, n_out_valid;
    logic signed [VB-1:0]      r_out,      n_out;

    logic signed [VB-1:0]      bl_a;
    logic signed [VB-1:0]      bl_b;
    logic [FB-1:0]             bl_f;
    logic signed [VB-1:0]      bl_res;
    logic [tvs_pkg::ADDR_W-1:0] rd_addr;
    logic                      res_load;

    // Neighbor k: bit 0 picks the upper x, bit 1 the upper y, bit 2 the upper z.
    always_comb begin
        rd_addr = (r_k[2] ? r_job.plane1 : r_job.plane0)
                + tvs_pkg::ADDR_W'(r_k[1] ? r_job.row1 : r_job.row0)
                + tvs_pkg::ADDR_W'(r_k[0] ? r_job.x1 : r_job.x0);
    end

    always_comb begin
        bl_a = r_lo;
        bl_b = $signed(i_rdata);
        bl_f = r_job.fx;
        case (r_state)
            ST_Y0: begin
                bl_a = r_c[0];
                bl_b = r_c[1];
                bl_f = r_job.fy;
            end
            ST_Y1: begin
                bl_a = r_c[2];
                bl_b = r_c[3];
                bl_f = r_job.fy;
            end
            ST_Z: begin
                bl_a = r_c0;
                bl_b = r_c1;
                bl_f = r_job.fz;
            end
            default: begin
            end
        endcase
    end

    assign bl_res = blend(bl_a, bl_b, bl_f);

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_k         = r_k;
        n_rvalid    = 1'b0;
        n_rk        = r_k;
        n_lo        = r_lo;
        n_c         = r_c;
        n_c0        = r_c0;
        n_c1        = r_c1;
        n_out_valid = r_out_valid && !i_out_pop;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        o_ram_req   = '{we: 1'b0, addr: rd_addr, wdata: i_q_data.wr_value};
        res_load    = 1'b0;

        // Read data for neighbor r_rk arrives in the cycle after its read.
        if (r_rvalid) begin
            if (!r_rk[0]) begin
                n_lo = $signed(i_rdata);
            end else begin
                n_c[r_rk[2:1]] = bl_res;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.is_sample) begin
                        n_job   = i_q_data;
                        n_k     = '0;
                        n_state = ST_READ;
                    end else begin
                        o_ram_req.we   = 1'b1;
                        o_ram_req.addr = i_q_data.wr_index;
                    end
                end
            end
            ST_READ: begin
                n_rvalid = 1'b1;
                n_k      = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_Y0;
            end
            ST_Y0: begin
                n_c0    = bl_res;
                n_state = ST_Y1;
            end
            ST_Y1: begin
                n_c1    = bl_res;
                n_state = ST_Z;
            end
            ST_Z: begin
                if (!r_out_valid || i_out_pop) begin
                    res_load    = 1'b1;
                    n_out       = bl_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
        end
        r_job <= n_job;
        r_rk  <= n_rk;
        r_lo  <= n_lo;
        r_c   <= n_c;
        r_c0  <= n_c0;
        r_c1  <= n_c1;
        r_out <= n_out;
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_value  = tvs_pkg::OUT_W'(r_out);
    assign o_stat.sampling = (r_state != ST_IDLE);
    assign o_stat.res_load = res_load;

endmodule

// ----- tb/sv/tb_trilinear_volume_sampler.sv -----
// Self-checking testbench for the trilinear volume sampler: voxel writes and samples go
// through the push/full side, results are popped and checked against a built-in predictor.
// Depends on tvs_pkg and the trilinear_volume_sampler top level.
module tb_trilinear_volume_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    import tvs_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_OPS     = 185;
    localparam int NUM_PHASES    = 9;
    localparam int HOLD_PHASE    = 6;
    localparam int MAX_PRINTS    = 100;

    // Size register values per phase; a negative entry means a random value.
    localparam int PHASE_SX [NUM_PHASES] = '{0, 63, 1, 32, 7, -1, 2, 1, -1};
    localparam int PHASE_SY [NUM_PHASES] = '{0, 63, 32, 1, 3, -1, 2, 1, -1};
    localparam int PHASE_SZ [NUM_PHASES] = '{0, 63, 5, 1, 63, -1, 2, 32, -1};

    typedef struct packed {
        logic                       cmd;
        logic [ADDR_W-1:0]          index;
        logic signed [IN_VAL_W-1:0] value;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic signed [COORD_W-1:0]  cz;
    } t_volume_op;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    wire                         full;
    logic                        i_command = CMD_WRITE;
    logic [ADDR_W-1:0]           i_voxel_index = '0;
    logic signed [IN_VAL_W-1:0]  i_voxel_value = '0;
    logic signed [COORD_W-1:0]   i_coord_x = '0;
    logic signed [COORD_W-1:0]   i_coord_y = '0;
    logic signed [COORD_W-1:0]   i_coord_z = '0;
    wire                         empty;
    logic                        pop = 1'b0;
    wire signed [OUT_W-1:0]      o_sample_value;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = REG_SIZE_X;
    logic [CFG_W-1:0]            i_cfg_data = '0;

    // Predictor state: voxel contents and size registers as the block should hold them.
    logic signed [VOXEL_BITS-1:0] vox_mem [STORE_DEPTH];
    logic [CFG_W-1:0]             size_reg [3] = '{6'd32, 6'd32, 6'd32};
    bit                           written_map [STORE_DEPTH];

    t_volume_op         volume_op_q [$];
    logic [OUT_W-1:0]   expected_sample_q [$];
    t_volume_op         drv_op;
    int                 err_cnt = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    logic               hold_arm = 1'b0;
    logic               hold_done = 1'b0;
    int                 hold_left = 0;
    int                 cycle_cnt = 0;

    trilinear_volume_sampler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_voxel_index  (i_voxel_index),
        .i_voxel_value  (i_voxel_value),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .empty          (empty),
        .pop            (pop),
        .o_sample_value (o_sample_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_size(logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > DIM_LIMIT) return DIM_LIMIT;
        return int'(r);
    endfunction

    // Position clamped to 0 .. (size-1) in fixed point.
    function automatic int clamp_pos(logic signed [COORD_W-1:0] raw, int size);
        int c;
        int hi;
        c = raw;
        hi = (size - 1) << FRAC_BITS;
        if (c < 0) c = 0;
        else if (c > hi) c = hi;
        return c;
    endfunction

    function automatic int axis_index(int c, int size, bit upper);
        int i0;
        i0 = c >>> FRAC_BITS;
        if (upper && i0 + 1 < size) return i0 + 1;
        return i0;
    endfunction

    // Corner k: bit 0 selects the upper x neighbor, bit 1 y, bit 2 z.
    function automatic int corner_addr(t_volume_op op, int k);
        int sx;
        int sy;
        int sz;
        sx = eff_size(size_reg[REG_SIZE_X]);
        sy = eff_size(size_reg[REG_SIZE_Y]);
        sz = eff_size(size_reg[REG_SIZE_Z]);
        return axis_index(clamp_pos(op.cz, sz), sz, k[2]) * sx * sy
             + axis_index(clamp_pos(op.cy, sy), sy, k[1]) * sx
             + axis_index(clamp_pos(op.cx, sx), sx, k[0]);
    endfunction

    function automatic int blend(int a, int b, int f);
        return (a * ((1 << FRAC_BITS) - f) + b * f) >>> FRAC_BITS;
    endfunction

    function automatic logic [OUT_W-1:0] interpolate(t_volume_op op);
        int v [8];
        int fx;
        int fy;
        int fz;
        int c00;
        int c01;
        int c10;
        int c11;
        int c0;
        int c1;
        int r;
        for (int k = 0; k < 8; k++) v[k] = vox_mem[corner_addr(op, k)];
        fx = clamp_pos(op.cx, eff_size(size_reg[REG_SIZE_X])) & ((1 << FRAC_BITS) - 1);
        fy = clamp_pos(op.cy, eff_size(size_reg[REG_SIZE_Y])) & ((1 << FRAC_BITS) - 1);
        fz = clamp_pos(op.cz, eff_size(size_reg[REG_SIZE_Z])) & ((1 << FRAC_BITS) - 1);
        c00 = blend(v[0], v[1], fx);
        c10 = blend(v[2], v[3], fx);
        c01 = blend(v[4], v[5], fx);
        c11 = blend(v[6], v[7], fx);
        c0 = blend(c00, c10, fy);
        c1 = blend(c01, c11, fy);
        r = blend(c0, c1, fz);
        return r[OUT_W-1:0];
    endfunction

    task automatic apply_volume_op(t_volume_op op);
        if (op.cmd == CMD_WRITE) vox_mem[op.index] = op.value;
        else expected_sample_q.push_back(interpolate(op));
    endtask

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %h expected %h", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic check_sample(logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] want;
        if (expected_sample_q.size() == 0) begin
            report_mismatch("sample_value with no sample pending", got, 'x);
        end else begin
            want = expected_sample_q.pop_front();
            if (got !== want) report_mismatch("sample_value", got, want);
        end
    endtask

    function automatic logic [VOXEL_BITS-1:0] rand_voxel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h8000;
        if (r < 20) return 16'h7FFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly inside the volume, some exact grid points, the rest anywhere in the range.
    function automatic logic [COORD_W-1:0] rand_coord(int size);
        int r;
        int hi;
        hi = ((size - 1) << FRAC_BITS) + (1 << FRAC_BITS) - 1;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, hi));
        if (r < 80) return 16'($urandom_range(0, size - 1) << FRAC_BITS);
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic queue_write(int idx, logic [VOXEL_BITS-1:0] val);
        t_volume_op op;
        op.cmd = CMD_WRITE;
        op.index = ADDR_W'(idx);
        op.value = val;
        op.cx = 16'($urandom_range(0, 65535));
        op.cy = 16'($urandom_range(0, 65535));
        op.cz = 16'($urandom_range(0, 65535));
        written_map[op.index] = 1'b1;
        volume_op_q.push_back(op);
    endtask

    // Any corner that was never written gets a write first, so no sample reads stale RAM.
    task automatic queue_sample(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                logic [COORD_W-1:0] cz);
        t_volume_op op;
        int a;
        op.cmd = CMD_SAMPLE;
        op.index = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
        op.value = 16'($urandom_range(0, 65535));
        op.cx = cx;
        op.cy = cy;
        op.cz = cz;
        for (int k = 0; k < 8; k++) begin
            a = corner_addr(op, k);
            if (!written_map[a]) queue_write(a, rand_voxel());
        end
        volume_op_q.push_back(op);
    endtask

    task automatic gen_random_op();
        int sx;
        int sy;
        int sz;
        int idx;
        sx = eff_size(size_reg[REG_SIZE_X]);
        sy = eff_size(size_reg[REG_SIZE_Y]);
        sz = eff_size(size_reg[REG_SIZE_Z]);
        if ($urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 99) < 70) idx = $urandom_range(0, sx * sy * sz - 1);
            else idx = $urandom_range(0, STORE_DEPTH - 1);
            queue_write(idx, rand_voxel());
        end else begin
            queue_sample(rand_coord(sx), rand_coord(sy), rand_coord(sz));
        end
    endtask

    // Idle means nothing left to send and every sample answered, then a settling pause
    // so that trailing voxel writes have drained inside the block.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (volume_op_q.size() != 0 || push || expected_sample_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_sizes(int x, int y, int z);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_SIZE_X;
        i_cfg_data <= CFG_W'(x);
        size_reg[REG_SIZE_X] = CFG_W'(x);
        @(posedge i_clk);
        i_cfg_index <= REG_SIZE_Y;
        i_cfg_data <= CFG_W'(y);
        size_reg[REG_SIZE_Y] = CFG_W'(y);
        @(posedge i_clk);
        i_cfg_index <= REG_SIZE_Z;
        i_cfg_data <= CFG_W'(z);
        size_reg[REG_SIZE_Z] = CFG_W'(z);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_size(int v);
        return (v < 0) ? int'($urandom_range(0, 63)) : v;
    endfunction

    // Driver: a held item stays on the ports until the transfer completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) begin
                drv_op = '{i_command, i_voxel_index, i_voxel_value, i_coord_x, i_coord_y,
                           i_coord_z};
                apply_volume_op(drv_op);
            end
            if (volume_op_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                drv_op = volume_op_q.pop_front();
                push <= 1'b1;
                i_command <= drv_op.cmd;
                i_voxel_index <= drv_op.index;
                i_voxel_value <= drv_op.value;
                i_coord_x <= drv_op.cx;
                i_coord_y <= drv_op.cy;
                i_coord_z <= drv_op.cz;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest pending sample.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_sample(o_sample_value);
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // One long receiver hold-off, so that the block backs up and raises full.
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct <= 38;
        rx_idle_pct <= 74;
        @(negedge i_clk);

        // Directed part with the reset sizes of 32 on every axis.
        queue_write(0, 16'h8000);
        queue_write(STORE_DEPTH - 1, 16'h7FFF);
        queue_write(16'h5555, 16'h5555);
        queue_write(16'h2AAA, 16'hAAAA);
        queue_sample(16'h0000, 16'h0000, 16'h0000);
        queue_sample(16'h8000, 16'h8000, 16'h8000);
        queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_sample(16'h00FF, 16'h00FF, 16'h00FF);
        queue_sample(16'h1F80, 16'h0080, 16'h1000);
        queue_sample(16'h0500, 16'h0A00, 16'h0F00);
        queue_sample(16'h7FFF, 16'h0000, 16'h8000);
        queue_sample(16'h1EFF, 16'h1F00, 16'hFFFF);
        queue_write(0, 16'h7FFF);
        queue_sample(16'h0000, 16'h0000, 16'h0000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_sizes(pick_size(PHASE_SX[p]), pick_size(PHASE_SY[p]), pick_size(PHASE_SZ[p]));
            mode = p * 3 / NUM_PHASES;
            tx_idle_pct <= (mode == 0) ? 38 : (mode == 1) ? 74 : 0;
            rx_idle_pct <= (mode == 0) ? 74 : (mode == 1) ? 38 : 0;
            @(negedge i_clk);
            if (p == HOLD_PHASE) hold_arm <= 1'b1;
            // Corner writes count toward the phase, so the item total stays bounded.
            while (volume_op_q.size() < PHASE_OPS) gen_random_op();
        end

        wait_idle();
        if (err_cnt == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
